// ===== rtl/kmv_distinct_count_sketch_defines.svh =====
// Assertion helpers used by the checker file
`ifndef KMV_DISTINCT_COUNT_SKETCH_DEFINES_SVH
`define KMV_DISTINCT_COUNT_SKETCH_DEFINES_SVH

// Same-cycle implication, held off during reset
`define KMV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define KMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define KMV_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kmv_pkg.sv =====
package kmv_pkg;

  localparam int SKETCH_SIZE_DEF = 64;
  localparam int HASH_W = 31;
  localparam int CNT_W = 11;
  localparam int EST_W = 48;
  // numerator (K-1) * full scale << 8 stays below 2^49 for K up to 1024
  localparam int NUM_W = 49;
  localparam int Q_FRAC = 8;

  localparam logic [HASH_W-1:0] HASH_FULL_SCALE = {HASH_W{1'b1}};
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE,
    ST_DIVIDE,
    ST_RESULT
  } kmv_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kmv_div_status_t;

endpackage

// ===== rtl/kmv_store.sv =====
module kmv_store import kmv_pkg::*; #(
  parameter int DEPTH = SKETCH_SIZE_DEF,
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [HASH_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [HASH_W-1:0] rdata
);

  logic [HASH_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kmv_div.sv =====
module kmv_div import kmv_pkg::*; #(
  parameter logic [NUM_W-1:0] NUMERATOR = '0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] divisor,
  output kmv_div_status_t   status,
  output logic [NUM_W-1:0]  quotient
);

  localparam int SW = $clog2(NUM_W + 1);

  logic            busy;
  logic            done;
  logic [SW-1:0]   steps;
  logic [HASH_W-1:0] rem;
  logic [HASH_W-1:0] dvs;
  logic [NUM_W-1:0]  quo;
  logic [HASH_W:0]   rem_sh;
  logic [HASH_W:0]   diff;
  logic              ge;

  // one restoring step: shift in the next numerator bit, trial subtract
  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff = rem_sh - {1'b0, dvs};
    ge = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= SW'(NUM_W);
        rem <= '0;
        quo <= NUMERATOR;
        dvs <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[HASH_W-1:0] : rem_sh[HASH_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient = quo;

endmodule

// ===== rtl/kmv_distinct_count_sketch.sv =====
// Bottom-K distinct-count sketch over 31-bit hash values.
// Input channel: in_valid / in_stall carrying mode and hash_value; a transfer
// takes place when in_valid is high and in_stall is low. mode 0 adds the
// value, mode 1 empties the sketch. Output channel: out_valid / out_stall
// carrying stored, entry_count and estimate_q8, one result per input item.
// excluded_value is written through cfg_we / cfg_wdata; the user must write
// it only while the block idles, which the block itself does not enforce.
// A clear or an excluded value goes straight to the result; other adds first
// scan the value memory (one read a cycle through its single read port),
// skipped on an empty sketch, then use the bit-serial divider when the
// sketch is full after the update, a value was stored or no estimate is
// cached, and its maximum is nonzero. One item is in work at a time;
// in_stall is high from transfer to result.
// A finished result waits in the output register while the next item is
// taken; if out_stall holds it, the following result waits in the block.
// Reset (rst, synchronous) empties the sketch and clears excluded_value; the
// value memory itself is not cleared, only entries below the count are read.
module kmv_distinct_count_sketch import kmv_pkg::*; #(
  parameter int SKETCH_SIZE = SKETCH_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [HASH_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [HASH_W-1:0] hash_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              stored,
  output logic [CNT_W-1:0]  entry_count,
  output logic [EST_W-1:0]  estimate_q8
);

  localparam int AW = (SKETCH_SIZE > 1) ? $clog2(SKETCH_SIZE) : 1;
  localparam logic [CNT_W-1:0] K_CNT = CNT_W'(SKETCH_SIZE);
  localparam logic [63:0] NUM_FULL =
    (64'(SKETCH_SIZE - 1) * 64'(HASH_FULL_SCALE)) << Q_FRAC;

  kmv_state_t state, state_next;

  logic [HASH_W-1:0] excl;
  logic [CNT_W-1:0]  count;
  logic [HASH_W-1:0] cur_max;
  logic [EST_W-1:0]  est_cache;
  logic              est_ok;
  logic [HASH_W-1:0] x_reg;
  logic              dup;
  logic [HASH_W-1:0] top;
  logic [HASH_W-1:0] second;
  logic [AW-1:0]     top_pos;
  logic [AW-1:0]     scan_idx;
  logic              rd_vld;
  logic [AW-1:0]     rd_pos;
  logic              res_stored;
  logic [EST_W-1:0]  res_est;

  logic              accept;
  logic              excl_hit;
  logic              full;
  logic [EST_W-1:0]  cur_est;
  logic              do_append;
  logic              do_replace;
  logic [CNT_W-1:0]  count_dec;
  logic [HASH_W-1:0] max_dec;
  logic              full_dec;
  logic              need_div;
  logic              out_load;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [HASH_W-1:0] rd_data;
  logic              div_start;
  kmv_div_status_t   div_st;
  logic [NUM_W-1:0]  div_q;
  logic [EST_W-1:0]  q_sat;

  kmv_store #(
    .DEPTH(SKETCH_SIZE),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(wr_en),
    .waddr(wr_addr),
    .wdata(x_reg),
    .re(rd_en),
    .raddr(scan_idx),
    .rdata(rd_data)
  );

  kmv_div #(
    .NUMERATOR(NUM_W'(NUM_FULL))
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .divisor(max_dec),
    .status(div_st),
    .quotient(div_q)
  );

  // decision terms for the current item
  always_comb begin
    in_stall = (state != ST_IDLE);
    accept = in_valid && !in_stall;
    excl_hit = (excl != '0) && (excl == hash_value);
    full = (count == K_CNT);
    cur_est = full ? est_cache : (EST_W'(count) << Q_FRAC);
    do_append = !dup && !full;
    do_replace = !dup && full && (top > x_reg);
    count_dec = do_append ? count + CNT_W'(1) : count;
    if (do_append) begin
      max_dec = (x_reg > cur_max) ? x_reg : cur_max;
    end else if (do_replace) begin
      max_dec = (x_reg > second) ? x_reg : second;
    end else begin
      max_dec = cur_max;
    end
    full_dec = (count_dec == K_CNT);
    need_div = full_dec && (do_append || do_replace || !est_ok) && (max_dec != '0);
    out_load = !out_valid || !out_stall;
    q_sat = (|div_q[NUM_W-1:EST_W]) ? EST_MAX : div_q[EST_W-1:0];
  end

  // next state and memory / divider strobes
  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_addr = top_pos;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode || excl_hit) begin
            state_next = ST_RESULT;
          end else if (count == '0) begin
            state_next = ST_DECIDE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx == AW'(count - CNT_W'(1))) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        wr_en = do_append || do_replace;
        wr_addr = do_append ? AW'(count) : top_pos;
        div_start = need_div;
        state_next = need_div ? ST_DIVIDE : ST_RESULT;
      end
      ST_DIVIDE: begin
        if (div_st.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the excluded value
  always_ff @(posedge clk) begin
    if (rst) begin
      excl <= '0;
    end else if (cfg_we) begin
      excl <= cfg_wdata;
    end
  end

  // read pipeline tag: data of a read arrives in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
    rd_pos <= scan_idx;
  end

  // sketch state and per-item working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cur_max <= '0;
      est_ok <= 1'b0;
      scan_idx <= '0;
    end else begin
      // accept: latch the item and settle clear or exclusion at once
      if (state == ST_IDLE && accept) begin
        x_reg <= hash_value;
        dup <= 1'b0;
        top <= '0;
        second <= '0;
        top_pos <= '0;
        scan_idx <= '0;
        res_stored <= 1'b0;
        if (mode) begin
          count <= '0;
          cur_max <= '0;
          est_ok <= 1'b0;
          res_est <= '0;
        end else begin
          res_est <= cur_est;
        end
      end
      // advance the scan address
      if (rd_en) begin
        scan_idx <= scan_idx + AW'(1);
      end
      // fold each returned entry into duplicate, maximum and runner-up
      if (rd_vld) begin
        if (rd_data == x_reg) begin
          dup <= 1'b1;
        end
        if (rd_data > top) begin
          second <= top;
          top <= rd_data;
          top_pos <= rd_pos;
        end else if (rd_data > second) begin
          second <= rd_data;
        end
      end
      // commit the update and pick the estimate source
      if (state == ST_DECIDE) begin
        count <= count_dec;
        cur_max <= max_dec;
        res_stored <= do_append || do_replace;
        if (!full_dec) begin
          res_est <= EST_W'(count_dec) << Q_FRAC;
        end else if (max_dec == '0) begin
          res_est <= EST_MAX;
          est_cache <= EST_MAX;
          est_ok <= 1'b1;
        end else if (!need_div) begin
          res_est <= est_cache;
        end
      end
      // take the quotient
      if (state == ST_DIVIDE && div_st.done) begin
        res_est <= q_sat;
        est_cache <= q_sat;
        est_ok <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == ST_RESULT && out_load) begin
      stored <= res_stored;
      entry_count <= count;
      estimate_q8 <= res_est;
    end
  end

endmodule

// ===== rtl/kmv_checker.sv =====
`include "kmv_distinct_count_sketch_defines.svh"

module kmv_checker import kmv_pkg::*; #(
  parameter int SKETCH_SIZE = SKETCH_SIZE_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              stored,
  input logic [CNT_W-1:0]  entry_count,
  input logic [EST_W-1:0]  estimate_q8
);

  localparam logic [CNT_W-1:0] K_CNT = CNT_W'(SKETCH_SIZE);

  logic                   in_take;
  logic                   out_held;
  logic [CNT_W+EST_W:0]   res_bits;
  logic                   partial;
  logic [EST_W-1:0]       partial_est;

  // terms seen on the ports
  assign in_take = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign res_bits = {stored, entry_count, estimate_q8};
  assign partial = out_valid && (entry_count < K_CNT);
  assign partial_est = EST_W'(entry_count) << Q_FRAC;

  // no result shown straight after reset
  `KMV_ASSERT_ALWAYS(a_reset_idle, rst, !out_valid, "result valid after reset")

  // a stalled result holds
  `KMV_ASSERT_NEXT(a_hold, out_held, out_valid && $stable(res_bits), "stalled result changed")

  // an input transfer keeps the input stalled while the item is in work
  `KMV_ASSERT_NEXT(a_busy, in_take, in_stall, "input open after transfer")

  // the count never passes the sketch size
  `KMV_ASSERT_NOW(a_count_bound, out_valid, entry_count <= K_CNT, "count beyond sketch size")

  // below full the estimate is the count in Q8
  `KMV_ASSERT_NOW(a_est_partial, partial, estimate_q8 == partial_est, "partial estimate mismatch")

endmodule

bind kmv_distinct_count_sketch kmv_checker #(
  .SKETCH_SIZE(SKETCH_SIZE)
) u_kmv_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .stored(stored),
  .entry_count(entry_count),
  .estimate_q8(estimate_q8)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kmv_pkg::*;

  localparam int K = SKETCH_SIZE_DEF;
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;
  localparam logic [HASH_W-1:0] HASH_TOP = {HASH_W{1'b1}};
  // settle time after a drain, with margin over the worst case per item
  localparam int SETTLE_CYCLES = 2 * K + 60;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam longint TIMEOUT_NS = 64'd15_000_000;

  typedef struct {
    logic             kept;
    logic [CNT_W-1:0] count;
    logic [EST_W-1:0] estimate;
  } sketch_result_t;

  // Bottom-K sketch mirror plus the queue of results it predicts
  class sketch_scoreboard;
    logic [HASH_W-1:0] held_values[K];
    logic [CNT_W-1:0]  held_count;
    logic [HASH_W-1:0] excluded;
    sketch_result_t    predicted[$];
    int unsigned       failures;
    int unsigned       n_items, n_clears, n_kept, n_full, n_checked;

    function new();
      foreach (held_values[i]) held_values[i] = '0;
      held_count = '0;
      excluded = '0;
      failures = 0;
      n_items = 0;
      n_clears = 0;
      n_kept = 0;
      n_full = 0;
      n_checked = 0;
    endfunction

    function void set_excluded(logic [HASH_W-1:0] v);
      excluded = v;
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function logic [EST_W-1:0] sketch_estimate();
      logic [HASH_W-1:0] top;
      logic [63:0] num;
      logic [63:0] quot;
      if (held_count < K) return EST_W'(held_count) << Q_FRAC;
      top = '0;
      for (int i = 0; i < K; i++) if (held_values[i] > top) top = held_values[i];
      if (top == 0) return EST_MAX;
      num = (64'(K - 1) * 64'(HASH_FULL_SCALE)) << Q_FRAC;
      quot = num / 64'(top);
      return (quot > 64'(EST_MAX)) ? EST_MAX : quot[EST_W-1:0];
    endfunction

    // Advance the mirror by one accepted input transfer
    function void record_transfer(logic m, logic [HASH_W-1:0] h);
      sketch_result_t r;
      logic dup;
      logic [HASH_W-1:0] top;
      int top_pos;
      r.kept = 1'b0;
      n_items++;
      if (m == MODE_CLEAR) begin
        held_count = '0;
        n_clears++;
      end else if (!(excluded != 0 && excluded == h)) begin
        dup = 1'b0;
        for (int i = 0; i < K; i++) if (i < held_count && held_values[i] == h) dup = 1'b1;
        if (!dup) begin
          if (held_count < K) begin
            held_values[held_count] = h;
            held_count = held_count + 1'b1;
            r.kept = 1'b1;
          end else begin
            // replace the largest held value, lowest position on a tie
            top = '0;
            top_pos = 0;
            for (int i = 0; i < K; i++) begin
              if (held_values[i] > top) begin
                top = held_values[i];
                top_pos = i;
              end
            end
            if (top > h) begin
              held_values[top_pos] = h;
              r.kept = 1'b1;
            end
          end
        end
      end
      r.count = held_count;
      r.estimate = sketch_estimate();
      if (r.kept) n_kept++;
      if (held_count == K) n_full++;
      predicted.insert(predicted.size(), r);
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_transfer(logic s, logic [CNT_W-1:0] c, logic [EST_W-1:0] e);
      sketch_result_t r;
      if (predicted.size() == 0) begin
        $error("result with nothing pending: stored %0d entry_count %0d estimate_q8 %0d",
               s, c, e);
        failures++;
        return;
      end
      r = predicted.pop_front();
      n_checked++;
      if (s !== r.kept) begin
        $error("stored: expected %0d, actual %0d", r.kept, s);
        failures++;
      end
      if (c !== r.count) begin
        $error("entry_count: expected %0d, actual %0d", r.count, c);
        failures++;
      end
      if (e !== r.estimate) begin
        $error("estimate_q8: expected %0d, actual %0d", r.estimate, e);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [HASH_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic              mode;
  logic [HASH_W-1:0] hash_value;
  logic              out_valid;
  logic              out_stall;
  logic              stored;
  logic [CNT_W-1:0]  entry_count;
  logic [EST_W-1:0]  estimate_q8;

  sketch_scoreboard  sb;
  logic              quiet;
  int                hold_requests;
  int                sender_idle_pct;
  logic [HASH_W-1:0] recent_hashes[$];

  kmv_distinct_count_sketch #(
    .SKETCH_SIZE(K)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .hash_value (hash_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stored     (stored),
    .entry_count(entry_count),
    .estimate_q8(estimate_q8)
  );

  always #5 clk = ~clk;

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_transfer(stored, entry_count, estimate_q8);
  end

  // Drive out_stall: random bursts, long hold-offs on request, none when quiet
  initial begin
    int stall_left;
    int open_left;
    int hold_left;
    int seen;
    stall_left = 0;
    open_left = 0;
    hold_left = 0;
    seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (open_left > 0) begin
        out_stall = 1'b0;
        open_left--;
      end else begin
        out_stall = 1'b0;
        stall_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 15) : 0;
        open_left = $urandom_range(1, 40);
      end
    end
  end

  // Hold one item on the input until it transfers, then predict its result
  task automatic send_item(input logic m, input logic [HASH_W-1:0] h);
    @(negedge clk);
    in_valid = 1'b1;
    mode = m;
    hash_value = h;
    do @(posedge clk); while (in_stall);
    sb.record_transfer(m, h);
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop valid and wait for every pending result, then let the block settle
  task automatic drain();
    idle_input(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_excluded(input logic [HASH_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_excluded(v);
  endtask

  // One setting of the register, opened with a clear, closed with a drain
  task automatic run_phase(input logic [HASH_W-1:0] excl, input logic long_hold);
    logic [HASH_W-1:0] h;
    logic m;
    int pick;
    write_excluded(excl);
    recent_hashes.delete();
    send_item(MODE_CLEAR, HASH_W'($urandom()));
    for (int n = 1; n < PHASE_ITEMS; n++) begin
      if (long_hold && n == 10) hold_requests++;
      if (!quiet && $urandom_range(0, 99) < sender_idle_pct)
        idle_input($urandom_range(1, 15));
      m = MODE_ADD;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        m = MODE_CLEAR;
        h = HASH_W'($urandom());
      end else if (pick < 6) begin
        h = excl;
      end else if (pick < 21 && recent_hashes.size() != 0) begin
        h = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
      end else if (pick < 45) begin
        h = HASH_W'($urandom_range(0, 255));
      end else if (pick < 55) begin
        h = HASH_TOP - HASH_W'($urandom_range(0, 4095));
      end else begin
        h = HASH_W'($urandom());
      end
      send_item(m, h);
      if (m == MODE_ADD) begin
        recent_hashes.insert(recent_hashes.size(), h);
        if (recent_hashes.size() > K) void'(recent_hashes.pop_front());
      end
    end
    drain();
  endtask

  initial begin
    logic [HASH_W-1:0] excl;
    int waited;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    mode = MODE_ADD;
    hash_value = '0;
    quiet = 1'b0;
    hold_requests = 0;
    sender_idle_pct = 20;

    // Hold reset, then release it
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: zero held while exclusion is off, duplicates, bit patterns, clears
    send_item(MODE_ADD, '0);
    send_item(MODE_ADD, '0);
    send_item(MODE_ADD, HASH_TOP);
    send_item(MODE_ADD, 31'h2AAA_AAAA);
    send_item(MODE_ADD, 31'h5555_5555);
    send_item(MODE_CLEAR, HASH_TOP);
    send_item(MODE_ADD, '0);
    send_item(MODE_CLEAR, '0);
    drain();
    // Directed: top value excluded, neighbours still kept
    write_excluded(HASH_TOP);
    send_item(MODE_ADD, HASH_TOP);
    send_item(MODE_ADD, HASH_TOP - 1'b1);
    send_item(MODE_ADD, '0);
    send_item(MODE_ADD, 31'd1);
    send_item(MODE_CLEAR, 31'h5555_5555);
    drain();

    // Random phases over a spread of excluded values; the last runs without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: excl = (p == 0) ? HASH_TOP : '0;
        1: excl = HASH_W'($urandom_range(1, 255));
        2: excl = HASH_W'($urandom());
        default: excl = '0;
      endcase
      sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      quiet = (p == NUM_PHASES - 1);
      run_phase(excl, p == 2);
    end

    // Wait for stragglers, with a limit
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.failures++;
    end

    $display("covered %0d items: %0d clears, %0d values kept, %0d results with a full sketch",
             sb.n_items, sb.n_clears, sb.n_kept, sb.n_full);
    $display("checked %0d results over %0d register settings", sb.n_checked, NUM_PHASES + 2);
    if (sb.failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== kmv_distinct_count_sketch.f =====
+incdir+rtl
rtl/kmv_pkg.sv
rtl/kmv_store.sv
rtl/kmv_div.sv
rtl/kmv_distinct_count_sketch.sv
rtl/kmv_checker.sv
verif/tb.sv
